### hdl/assert_macros.svh
// Assertion helper macros for the class file layout parser.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/cflp_pkg.sv
// Package for the class file layout parser: sizes, codes and a lookup function.
// Used by class_file_layout_parser_top; depends on nothing else.
`default_nettype none
package cflp_pkg;
    localparam int POOL_DEPTH = 1024;
    localparam int TBL_AW     = $clog2(POOL_DEPTH);
    localparam int OUT_W      = 168;

    localparam logic [31:0] MAGIC_WORD     = 32'hcafebabe;
    localparam logic [15:0] ACC_STATIC_BIT = 16'h0008;

    // Constant pool tags with a special payload size.
    localparam logic [7:0] TAG_UTF8    = 8'd1;
    localparam logic [7:0] TAG_LONG    = 8'd5;
    localparam logic [7:0] TAG_DOUBLE  = 8'd6;
    localparam logic [7:0] TAG_CLASS   = 8'd7;
    localparam logic [7:0] TAG_STRING  = 8'd8;
    localparam logic [7:0] TAG_MHANDLE = 8'd15;
    localparam logic [7:0] TAG_MTYPE   = 8'd16;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MAGIC    = 2'd1;
    localparam logic [1:0] ST_POOL     = 2'd2;
    localparam logic [1:0] ST_DESC     = 2'd3;

    // Byte size of a field from the first character of its descriptor.
    function automatic logic [3:0] size_of_char(input logic [7:0] c);
        logic [3:0] sz;
        begin
            unique case (c)
                "B", "Z": sz = 4'd1;
                "C", "S": sz = 4'd2;
                "D", "J": sz = 4'd8;
                default:  sz = 4'd4;
            endcase
            return sz;
        end
    endfunction
endpackage
`default_nettype wire

### hdl/class_file_layout_parser_top.sv
// Class file layout parser, top level and only module.
// Depends on cflp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Takes a class file one byte per transaction on the slave stream, tuser marking
// the first byte of a new file, and gives one result transaction per file after the
// method count (or at once on a bad magic word, an oversized constant pool or a bad
// descriptor index). Bytes are accepted back to back, one per cycle, but for the stall below.
// The first descriptor character of each pool entry is kept in a synchronous table of
// POOL_DEPTH entries with one write and one read port; a field's size lookup reads it in the
// cycle the descriptor index completes and the total is updated in the next cycle.
// The input stalls only when a result is waiting and the next byte could produce
// another one. Table entries are not cleared at reset; every entry that a descriptor
// may name is written while the pool of the same file is walked.
module class_file_layout_parser_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // data_byte
    input  wire logic                   s_axis_tuser,   // first_byte
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[1:0], pool_count, class_flags, this_class_index, super_class_index,
    // interfaces_offset, fields_offset, methods_offset, class_var_bytes,
    // instance_var_bytes, method_count (16 bits each), zero padding
    output logic [cflp_pkg::OUT_W-1:0]  m_axis_tdata
);
    import cflp_pkg::*;

    typedef enum logic [4:0] {
        PH_MAGIC, PH_VERSION, PH_PCOUNT, PH_TAG, PH_UTFLEN, PH_UTFFIRST, PH_PSKIP,
        PH_ACCESS, PH_THIS, PH_SUPER, PH_ICOUNT, PH_IFACES, PH_FCOUNT,
        PH_FACC, PH_FNAME, PH_FDESC, PH_FATTRS, PH_ANAME, PH_ALEN, PH_ABODY,
        PH_MCOUNT, PH_DONE
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [15:0]  r_pos, n_pos;
    logic [31:0]  r_gather, n_gather;
    logic [1:0]   r_cnt, n_cnt;
    logic [31:0]  r_skip, n_skip;
    logic [15:0]  r_entry, n_entry;
    logic [15:0]  r_etotal, n_etotal;
    logic [15:0]  r_items, n_items;
    logic [15:0]  r_attrs, n_attrs;
    logic         r_fstatic, n_fstatic;
    logic [15:0]  r_hdr [6];
    logic [15:0]  n_hdr [6];
    logic [15:0]  r_static, r_inst;
    logic         r_add_pend, n_add_pend;
    logic         r_add_static;
    logic         r_pw_valid, n_pw_valid;
    logic [TBL_AW-1:0] r_pw_addr, n_pw_addr;
    logic         r_m_valid;
    logic [OUT_W-1:0] r_m_data;

    logic [7:0]   r_table [POOL_DEPTH];
    logic [7:0]   r_rd_data;

    logic         acc, first, near_emit, emit;
    logic [1:0]   emit_status;
    logic [15:0]  emit_moff, emit_mcount;
    logic         wr_en;
    logic [TBL_AW-1:0] wr_addr, rd_addr;
    logic [7:0]   wr_data;
    logic [3:0]   add_size;

    assign first = s_axis_tuser;
    assign acc   = s_axis_tvalid && s_axis_tready;

    // Only a byte at the end of a gathered word can raise a result.
    assign near_emit = (r_phase == PH_MAGIC  && r_cnt == 2'd3) ||
                       (r_phase == PH_PCOUNT && r_cnt == 2'd1) ||
                       (r_phase == PH_FDESC  && r_cnt == 2'd1) ||
                       (r_phase == PH_MCOUNT && r_cnt == 2'd1);
    assign s_axis_tready = !(r_m_valid && !m_axis_tready && near_emit);

    // Parse step for one byte.
    always_comb begin
        t_phase      c_phase;
        logic [15:0] c_pos;
        logic [31:0] c_gather, g;
        logic [1:0]  c_cnt;
        logic        done2, done4;
        logic [15:0] slot, idx;
        logic [16:0] e16;
        c_phase  = first ? PH_MAGIC : r_phase;
        c_pos    = first ? 16'd0 : r_pos;
        c_gather = first ? 32'd0 : r_gather;
        c_cnt    = first ? 2'd0 : r_cnt;
        g        = {c_gather[23:0], s_axis_tdata};
        done2    = (c_cnt == 2'd1);
        done4    = (c_cnt == 2'd3);
        slot     = 16'd0;
        idx      = g[15:0];
        e16      = 17'd0;

        n_phase   = c_phase;
        n_pos     = c_pos + 16'd1;
        n_gather  = c_gather;
        n_cnt     = c_cnt;
        n_skip    = r_skip;
        n_entry   = r_entry;
        n_etotal  = r_etotal;
        n_items   = r_items;
        n_attrs   = r_attrs;
        n_fstatic = r_fstatic;
        for (int k = 0; k < 6; k++) n_hdr[k] = first ? 16'd0 : r_hdr[k];
        n_add_pend  = 1'b0;
        n_pw_valid  = 1'b0;
        n_pw_addr   = r_pw_addr;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_moff   = 16'd0;
        emit_mcount = 16'd0;
        wr_en       = 1'b0;
        wr_addr     = r_entry[TBL_AW-1:0];
        wr_data     = 8'd0;
        rd_addr     = idx[TBL_AW-1:0] - TBL_AW'(1);

        // Gathering phases shift the byte in and count it.
        if (c_phase == PH_MAGIC || c_phase == PH_VERSION || c_phase == PH_PCOUNT ||
            c_phase == PH_UTFLEN || c_phase == PH_ACCESS || c_phase == PH_THIS ||
            c_phase == PH_SUPER || c_phase == PH_ICOUNT || c_phase == PH_FCOUNT ||
            c_phase == PH_FACC || c_phase == PH_FNAME || c_phase == PH_FDESC ||
            c_phase == PH_FATTRS || c_phase == PH_ANAME || c_phase == PH_ALEN ||
            c_phase == PH_MCOUNT) begin
            n_gather = g;
            n_cnt    = c_cnt + 2'd1;
        end

        unique case (c_phase)
            PH_MAGIC: begin
                if (done4) begin
                    n_cnt = 2'd0;
                    if (g != MAGIC_WORD) begin
                        emit = 1'b1;
                        emit_status = ST_MAGIC;
                    end else begin
                        n_phase = PH_VERSION;
                    end
                end
            end
            PH_VERSION: if (done4) begin
                n_cnt = 2'd0;
                n_phase = PH_PCOUNT;
            end
            PH_PCOUNT: if (done2) begin
                n_cnt    = 2'd0;
                n_hdr[0] = g[15:0];
                n_etotal = g[15:0] - 16'd1;
                n_entry  = 16'd0;
                if ({1'b0, n_etotal} > 17'(POOL_DEPTH)) begin
                    emit = 1'b1;
                    emit_status = ST_POOL;
                end else begin
                    n_phase = (n_etotal == 16'd0) ? PH_ACCESS : PH_TAG;
                end
            end
            PH_TAG: begin
                slot    = r_entry;
                wr_en   = ({1'b0, slot} < 17'(POOL_DEPTH));
                wr_addr = slot[TBL_AW-1:0];
                if (s_axis_tdata == TAG_UTF8) begin
                    n_phase = PH_UTFLEN;
                end else begin
                    if (s_axis_tdata == TAG_CLASS || s_axis_tdata == TAG_STRING ||
                        s_axis_tdata == TAG_MTYPE) begin
                        n_skip = 32'd2;
                    end else if (s_axis_tdata == TAG_MHANDLE) begin
                        n_skip = 32'd3;
                    end else if (s_axis_tdata == TAG_LONG || s_axis_tdata == TAG_DOUBLE) begin
                        // Second slot is written in the next cycle.
                        n_entry    = r_entry + 16'd1;
                        n_pw_valid = ({1'b0, n_entry} < 17'(POOL_DEPTH));
                        n_pw_addr  = n_entry[TBL_AW-1:0];
                        n_skip     = 32'd8;
                    end else begin
                        n_skip = 32'd4;
                    end
                    n_phase = PH_PSKIP;
                end
            end
            PH_UTFLEN: if (done2) begin
                n_cnt  = 2'd0;
                n_skip = {16'd0, g[15:0]};
                if (g[15:0] == 16'd0) begin
                    n_entry = r_entry + 16'd1;
                    n_phase = (n_entry >= r_etotal) ? PH_ACCESS : PH_TAG;
                end else begin
                    n_phase = PH_UTFFIRST;
                end
            end
            PH_UTFFIRST: begin
                wr_en   = ({1'b0, r_entry} < 17'(POOL_DEPTH));
                wr_data = s_axis_tdata;
                n_skip  = r_skip - 32'd1;
                if (n_skip == 32'd0) begin
                    n_entry = r_entry + 16'd1;
                    n_phase = (n_entry >= r_etotal) ? PH_ACCESS : PH_TAG;
                end else begin
                    n_phase = PH_PSKIP;
                end
            end
            PH_PSKIP: begin
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'd0) begin
                    n_entry = r_entry + 16'd1;
                    n_phase = (n_entry >= r_etotal) ? PH_ACCESS : PH_TAG;
                end
            end
            PH_ACCESS: if (done2) begin
                n_cnt = 2'd0; n_hdr[1] = g[15:0]; n_phase = PH_THIS;
            end
            PH_THIS: if (done2) begin
                n_cnt = 2'd0; n_hdr[2] = g[15:0]; n_phase = PH_SUPER;
            end
            PH_SUPER: if (done2) begin
                n_cnt = 2'd0; n_hdr[3] = g[15:0]; n_phase = PH_ICOUNT;
            end
            PH_ICOUNT: if (done2) begin
                n_cnt    = 2'd0;
                n_hdr[4] = n_pos;
                n_skip   = {15'd0, g[15:0], 1'b0};
                n_phase  = (g[15:0] == 16'd0) ? PH_FCOUNT : PH_IFACES;
            end
            PH_IFACES: begin
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'd0) n_phase = PH_FCOUNT;
            end
            PH_FCOUNT: if (done2) begin
                n_cnt    = 2'd0;
                n_hdr[5] = n_pos;
                n_items  = g[15:0];
                n_phase  = (g[15:0] == 16'd0) ? PH_MCOUNT : PH_FACC;
            end
            PH_FACC: if (done2) begin
                n_cnt     = 2'd0;
                n_fstatic = |(g[15:0] & ACC_STATIC_BIT);
                n_phase   = PH_FNAME;
            end
            PH_FNAME: if (done2) begin
                n_cnt = 2'd0; n_phase = PH_FDESC;
            end
            PH_FDESC: if (done2) begin
                n_cnt = 2'd0;
                e16   = {1'b0, r_etotal};
                if (idx == 16'd0 || {1'b0, idx} > e16 || {1'b0, idx} > 17'(POOL_DEPTH)) begin
                    emit = 1'b1;
                    emit_status = ST_DESC;
                end else begin
                    // Table read now, size added in the next cycle.
                    n_add_pend = 1'b1;
                    n_phase    = PH_FATTRS;
                end
            end
            PH_FATTRS: if (done2) begin
                n_cnt   = 2'd0;
                n_attrs = g[15:0];
                if (g[15:0] == 16'd0) begin
                    n_items = r_items - 16'd1;
                    n_phase = (n_items == 16'd0) ? PH_MCOUNT : PH_FACC;
                end else begin
                    n_phase = PH_ANAME;
                end
            end
            PH_ANAME: if (done2) begin
                n_cnt = 2'd0; n_phase = PH_ALEN;
            end
            PH_ALEN: if (done4) begin
                n_cnt  = 2'd0;
                n_skip = g;
                if (g == 32'd0) begin
                    n_attrs = r_attrs - 16'd1;
                    if (n_attrs == 16'd0) begin
                        n_items = r_items - 16'd1;
                        n_phase = (n_items == 16'd0) ? PH_MCOUNT : PH_FACC;
                    end else begin
                        n_phase = PH_ANAME;
                    end
                end else begin
                    n_phase = PH_ABODY;
                end
            end
            PH_ABODY: begin
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'd0) begin
                    n_attrs = r_attrs - 16'd1;
                    if (n_attrs == 16'd0) begin
                        n_items = r_items - 16'd1;
                        n_phase = (n_items == 16'd0) ? PH_MCOUNT : PH_FACC;
                    end else begin
                        n_phase = PH_ANAME;
                    end
                end
            end
            PH_MCOUNT: if (done2) begin
                n_cnt       = 2'd0;
                emit        = 1'b1;
                emit_status = ST_OK;
                emit_moff   = n_pos;
                emit_mcount = g[15:0];
            end
            PH_DONE: begin
                n_pos = c_pos;
            end
            default: ;
        endcase
        if (emit) n_phase = PH_DONE;
    end

    assign add_size = size_of_char(r_rd_data);

    // Parser state and field totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC;
            r_pos      <= 16'd0;
            r_gather   <= 32'd0;
            r_cnt      <= 2'd0;
            r_skip     <= 32'd0;
            r_entry    <= 16'd0;
            r_etotal   <= 16'd0;
            r_items    <= 16'd0;
            r_attrs    <= 16'd0;
            r_fstatic  <= 1'b0;
            for (int k = 0; k < 6; k++) r_hdr[k] <= 16'd0;
            r_static   <= 16'd0;
            r_inst     <= 16'd0;
            r_add_pend <= 1'b0;
            r_pw_valid <= 1'b0;
        end else begin
            r_add_pend <= acc && n_add_pend;
            r_pw_valid <= acc && n_pw_valid;
            // A new file clears the totals; otherwise a pending size is added.
            if (acc && first) begin
                r_static <= 16'd0;
                r_inst   <= 16'd0;
            end else if (r_add_pend) begin
                if (r_add_static) r_static <= r_static + {12'd0, add_size};
                else              r_inst   <= r_inst + {12'd0, add_size};
            end
            if (acc) begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_gather   <= n_gather;
                r_cnt      <= n_cnt;
                r_skip     <= n_skip;
                r_entry    <= n_entry;
                r_etotal   <= n_etotal;
                r_items    <= n_items;
                r_attrs    <= n_attrs;
                r_fstatic  <= n_fstatic;
                for (int k = 0; k < 6; k++) r_hdr[k] <= n_hdr[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw_addr    <= n_pw_addr;
        r_add_static <= r_fstatic;
    end

    // First character table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_pw_valid) begin
            r_table[r_pw_addr] <= 8'd0;
        end else if (acc && wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        r_rd_data <= r_table[rd_addr];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (acc && emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_m_data <= {6'd0, emit_mcount, r_inst, r_static, emit_moff, n_hdr[5], n_hdr[4],
                         n_hdr[3], n_hdr[2], n_hdr[1], n_hdr[0], emit_status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `ASSERT_IMPL(a_one_write_port, r_pw_valid, !(acc && wr_en))
    `ASSERT_IMPL(a_no_result_overrun, acc && emit, !(r_m_valid && !m_axis_tready))
    `ASSERT_NEXT(a_add_single, r_add_pend, !r_add_pend)
    `ASSERT_IMPL(a_done_no_add, r_phase == PH_DONE, !r_add_pend)
endmodule
`default_nettype wire
